// ===== hw/rtl/srrw_pkg.sv =====
`timescale 1ns / 1ps

package srrw_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int WIN_W = SLOT_W + 1;
    localparam int SEQ_W = 32;
    localparam int LEN_W = 11;
    localparam logic [LEN_W-1:0] MAX_LEN = 11'd1456;

    localparam logic [1:0] OP_SYN  = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_FIN  = 2'd2;

    typedef enum logic [1:0] {
        KIND_STORE    = 2'd0,
        KIND_DELIVER  = 2'd1,
        KIND_BUFFERED = 2'd2,
        KIND_ACK      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACK_SEQ  = 2'd0,
        ACK_SYN  = 2'd1,
        ACK_BASE = 2'd2
    } ack_src_t;

    typedef struct packed {
        logic     load;
        logic     emit;
        kind_t    kind;
        ack_src_t ack_src;
        logic     last;
        logic     syn_open;
        logic     fin_close;
        logic     store;
        logic     deliver;
        logic     walk_step;
        logic     advance;
    } cmd_t;

    typedef struct packed {
        logic       connected;
        logic [1:0] op;
        logic       crc_ok;
        logic       stale;
        logic       in_win;
        logic       in_order;
        logic       walk_more;
        logic       out_free;
    } status_t;

endpackage

// ===== hw/rtl/selective_repeat_receive_window_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid / in_ready       op, seq, len, crc_ok
// output    out_valid / out_ready     kind, ack_seq, slot, length, last
// config    cfg_we                    cfg_wdata (window_size)
//
// A header is taken only while the controller is idle; it is decoded in the next cycle.
// Each result beat is then loaded into the output register, and after an in-order delivery run
// the base is advanced in a step of its own before the closing acknowledgement.
// A stalled output register holds the controller in its emitting state.
// Reset clears the connection, the window base and every slot valid bit at once.

module selective_repeat_receive_window_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [srrw_pkg::WIN_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic [srrw_pkg::SEQ_W-1:0]     seq,
    input  logic [srrw_pkg::LEN_W-1:0]     len,
    input  logic                           crc_ok,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [srrw_pkg::SEQ_W-1:0]     ack_seq,
    output logic [srrw_pkg::SLOT_W-1:0]    slot,
    output logic [srrw_pkg::LEN_W-1:0]     length,
    output logic                           last
);
    import srrw_pkg::*;

    cmd_t    cmd;
    status_t st;

    srrw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    srrw_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .seq       (seq),
        .len       (len),
        .crc_ok    (crc_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .ack_seq   (ack_seq),
        .slot      (slot),
        .length    (length),
        .last      (last),
        .cmd       (cmd),
        .st        (st)
    );

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("result beat loaded over a pending beat");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.syn_open, cmd.fin_close, cmd.store,
                  cmd.deliver, cmd.walk_step, cmd.advance}))
        else $error("more than one state update in a cycle");

    a_walk_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (cmd.emit && cmd.kind == KIND_BUFFERED && !cmd.last))
        else $error("buffered delivery without its beat");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.emit)
        else $error("result beat while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("header taken while another is decoded");

endmodule

// ===== hw/rtl/srrw_ctrl.sv =====
`timescale 1ns / 1ps

module srrw_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  srrw_pkg::status_t st,
    output srrw_pkg::cmd_t    cmd
);
    import srrw_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECIDE  = 8'b0000_0010,
        S_SYN     = 8'b0000_0100,
        S_FIN     = 8'b0000_1000,
        S_STORE   = 8'b0001_0000,
        S_ACK     = 8'b0010_0000,
        S_DELIVER = 8'b0100_0000,
        S_WALK    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.kind = KIND_ACK;
        cmd.ack_src = ACK_BASE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!st.connected)
                begin
                    state_next = (st.op == OP_SYN) ? S_SYN : S_IDLE;
                end
                else if (st.op == OP_FIN)
                begin
                    state_next = S_FIN;
                end
                else if (st.op != OP_DATA || !st.crc_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (st.stale)
                begin
                    state_next = S_ACK;
                end
                else if (!st.in_win)
                begin
                    state_next = S_IDLE;
                end
                else if (st.in_order)
                begin
                    state_next = S_DELIVER;
                end
                else
                begin
                    state_next = S_STORE;
                end
            end
            S_SYN:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_ACK;
                    cmd.ack_src = ACK_SEQ;
                    cmd.last = 1'b1;
                    cmd.syn_open = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_ACK;
                    cmd.ack_src = ACK_SYN;
                    cmd.last = 1'b1;
                    cmd.fin_close = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_STORE:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_STORE;
                    cmd.store = 1'b1;
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_ACK;
                    cmd.ack_src = ACK_BASE;
                    cmd.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DELIVER:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_DELIVER;
                    cmd.deliver = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (!st.walk_more)
                begin
                    cmd.advance = 1'b1;
                    state_next = S_ACK;
                end
                else if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_BUFFERED;
                    cmd.walk_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/srrw_dp.sv =====
`timescale 1ns / 1ps

module srrw_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [srrw_pkg::WIN_W-1:0]     cfg_wdata,
    input  logic [1:0]                     op,
    input  logic [srrw_pkg::SEQ_W-1:0]     seq,
    input  logic [srrw_pkg::LEN_W-1:0]     len,
    input  logic                           crc_ok,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [srrw_pkg::SEQ_W-1:0]     ack_seq,
    output logic [srrw_pkg::SLOT_W-1:0]    slot,
    output logic [srrw_pkg::LEN_W-1:0]     length,
    output logic                           last,
    input  srrw_pkg::cmd_t                 cmd,
    output srrw_pkg::status_t              st
);
    import srrw_pkg::*;

    logic [WIN_W-1:0]      window_size_reg;
    logic                  connected_reg;
    logic [SEQ_W-1:0]      base_reg;
    logic [SEQ_W-1:0]      syn_reg;
    logic [WINDOW_MAX-1:0] valid_reg;
    logic [LEN_W-1:0]      slot_len_reg [WINDOW_MAX];
    logic [WIN_W-1:0]      walk_n_reg;

    logic [1:0]            op_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  crc_reg;

    logic                  out_valid_reg;
    logic [1:0]            kind_reg;
    logic [SEQ_W-1:0]      ack_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [LEN_W-1:0]      length_reg;
    logic                  last_reg;

    logic [WIN_W-1:0]      w_eff;
    logic [SEQ_W-1:0]      seq_off;
    logic [SLOT_W-1:0]     walk_slot;
    logic [SLOT_W-1:0]     store_slot;
    logic [SEQ_W-1:0]      ack_next;
    logic [SLOT_W-1:0]     slot_next;
    logic [LEN_W-1:0]      length_next;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (window_size_reg > WIN_W'(WINDOW_MAX))
        begin
            w_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = window_size_reg;
        end
    end

    assign seq_off = seq_reg - base_reg;
    assign walk_slot = base_reg[SLOT_W-1:0] + walk_n_reg[SLOT_W-1:0];
    assign store_slot = seq_reg[SLOT_W-1:0];

    assign st.connected = connected_reg;
    assign st.op = op_reg;
    assign st.crc_ok = crc_reg;
    assign st.stale = seq_off[SEQ_W-1];
    assign st.in_win = (seq_off < {{(SEQ_W-WIN_W){1'b0}}, w_eff});
    assign st.in_order = (seq_off == '0);
    assign st.walk_more = (walk_n_reg < w_eff) && valid_reg[walk_slot];
    assign st.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        ack_next = '0;
        slot_next = '0;
        length_next = '0;
        case (cmd.kind)
            KIND_STORE:
            begin
                slot_next = store_slot;
                length_next = len_reg;
            end
            KIND_DELIVER:
            begin
                length_next = len_reg;
            end
            KIND_BUFFERED:
            begin
                slot_next = walk_slot;
                length_next = slot_len_reg[walk_slot];
            end
            KIND_ACK:
            begin
                case (cmd.ack_src)
                    ACK_SEQ:  ack_next = seq_reg;
                    ACK_SYN:  ack_next = syn_reg;
                    default:  ack_next = base_reg;
                endcase
            end
            default:
            begin
                ack_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_W'(WINDOW_MAX);
            connected_reg <= 1'b0;
            base_reg <= '0;
            syn_reg <= '0;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
            if (cmd.syn_open)
            begin
                connected_reg <= 1'b1;
                syn_reg <= seq_reg;
                base_reg <= '0;
                valid_reg <= '0;
            end
            if (cmd.fin_close)
            begin
                connected_reg <= 1'b0;
            end
            if (cmd.store)
            begin
                valid_reg[store_slot] <= 1'b1;
            end
            if (cmd.deliver)
            begin
                valid_reg[base_reg[SLOT_W-1:0]] <= 1'b0;
            end
            if (cmd.walk_step)
            begin
                valid_reg[walk_slot] <= 1'b0;
            end
            if (cmd.advance)
            begin
                base_reg <= base_reg + {{(SEQ_W-WIN_W){1'b0}}, walk_n_reg};
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            seq_reg <= seq;
            len_reg <= (len > MAX_LEN) ? MAX_LEN : len;
            crc_reg <= crc_ok;
        end
        if (cmd.store)
        begin
            slot_len_reg[store_slot] <= len_reg;
        end
        if (cmd.deliver)
        begin
            walk_n_reg <= WIN_W'(1);
        end
        else if (cmd.walk_step)
        begin
            walk_n_reg <= walk_n_reg + WIN_W'(1);
        end
        if (cmd.emit)
        begin
            kind_reg <= cmd.kind;
            ack_reg <= ack_next;
            slot_reg <= slot_next;
            length_reg <= length_next;
            last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign ack_seq = ack_reg;
    assign slot = slot_reg;
    assign length = length_reg;
    assign last = last_reg;

endmodule
